// ----- rtl/core/sound_channel_regs_mixer_assert.svh -----
// Assertion macros for the sound channel register mixer.
// Expect clk and rst_n in the scope of each use.
`ifndef SOUND_CHANNEL_REGS_MIXER_ASSERT_SVH
`define SOUND_CHANNEL_REGS_MIXER_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define SNDMIX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define SNDMIX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sndmix_pkg.sv -----
// Shared constants and types of the sound channel register mixer.
// Used by sndmix_chan_mem and sound_channel_regs_mixer; depends on nothing.
package sndmix_pkg;

    // Geometry and timing
    localparam int CHANNELS          = 4;
    localparam int CYCLES_PER_SAMPLE = 64;
    localparam int CH_W              = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TICK_W            = 16;

    // Mixer arithmetic widths
    localparam int VOICE_W  = 15;                  // data * (vol >> 2)
    localparam int ACC_W    = VOICE_W + CH_W;      // sum over all channels
    localparam int PROD_W   = ACC_W + 7;           // sum * (master >> 2)
    localparam int MIX_DIV  = CHANNELS * 4;        // power of two
    localparam int PEAK_SHIFT = 6;

    // Register constants
    localparam logic [7:0] VOL_MASK      = 8'hFC;
    localparam logic [7:0] MVOL_RESET    = 8'h3F;
    localparam logic [7:0] CTRL_ACT      = 8'h80;
    localparam logic [7:0] CTRL_LOOP     = 8'h01;
    localparam logic [7:0] UNMAPPED_DATA = 8'd255;

    typedef logic [CH_W-1:0] chan_idx_t;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        REG_DATA     = 4'd0,
        REG_BANK     = 4'd1,
        REG_ADDR_HI  = 4'd2,
        REG_ADDR_LO  = 4'd3,
        REG_PER_HI   = 4'd4,
        REG_PER_LO   = 4'd5,
        REG_LEN_HI   = 4'd6,
        REG_LEN_LO   = 4'd7,
        REG_CTRL     = 4'd8,
        REG_VOL      = 4'd9,
        REG_REP_HI   = 4'd10,
        REG_REP_LO   = 4'd11,
        REG_PEAK     = 4'd12,
        REG_UNMAPPED = 4'd13,
        REG_MVOL     = 4'd14,
        REG_SELECT   = 4'd15
    } reg_t;

    // One channel entry of the state memory
    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  bank;
        logic [15:0] address;
        logic [7:0]  period_latch;
        logic [15:0] period;
        logic [15:0] length;
        logic [15:0] repeat_offset;
        logic        active;
        logic        loop_en;
        logic [7:0]  volume;
        logic [7:0]  peak;
    } chan_t;

    // Access request from the controller to the channel memory
    typedef struct packed {
        logic      rd_en;
        chan_idx_t rd_idx;
        logic      wr_en;
        chan_idx_t wr_idx;
        chan_t     wr_data;
    } mem_req_t;

endpackage

// ----- rtl/core/sound_channel_regs_mixer.sv -----
// Sound channel register file with a periodic mixer (top level).
// Depends on sndmix_pkg, sndmix_chan_mem and sound_channel_regs_mixer_assert.svh.
//
// Usage:
//   The s_ channel takes one transaction per item: a register write, a register
//   read, or one system clock tick. The m_ channel returns exactly one
//   transaction per item: the read byte (255 for the unmapped index, 0 for
//   writes and ticks), a sample flag in m_tuser and the mixed sample.
//   Register accesses go to the channel picked by the select register.
//   Sequencing: a write, a read or a tick that does not mix is accepted, its
//   channel-memory entry is read, and the result is registered into the output
//   register from S_ACCESS. A mixing tick, every CYCLES_PER_SAMPLE ticks, reads
//   the channels one per cycle from the single-read-port channel memory in
//   S_MIX, then multiplies in S_SCALE and scales and saturates in S_FINISH.
//   Reset: all channel registers read as zero, master volume as 0x3F, tick
//   count and select as zero; no clearing pass is needed.
//   Stall: the output register holds a result while m_tready is low; the next
//   item is still accepted and stops only when its own result is ready.
`include "sound_channel_regs_mixer_assert.svh"

module sound_channel_regs_mixer
    import sndmix_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [1:0] mode, [5:2] reg_addr, [13:6] write_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] read_data, [23:8] mixed_sample
    output logic [0:0]  m_tuser     // [0] sample_valid
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ACCESS = 5'b00010,
        S_MIX    = 5'b00100,
        S_SCALE  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    localparam chan_idx_t LAST_CHAN = CH_W'(CHANNELS - 1);

    state_t                   state_reg, state_next;
    mode_t                    mode_reg, mode_next;
    reg_t                     addr_reg, addr_next;
    logic [7:0]               wdata_reg, wdata_next;
    logic [TICK_W-1:0]        tick_reg, tick_next;
    logic [7:0]               mvol_reg, mvol_next;
    chan_idx_t                sel_reg, sel_next;
    chan_idx_t                proc_idx_reg, proc_idx_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     out_valid_reg, out_valid_next;
    logic [7:0]               out_rdata_reg, out_rdata_next;
    logic                     out_sv_reg, out_sv_next;
    logic [15:0]              out_sample_reg, out_sample_next;

    mem_req_t                 mem_req;
    chan_t                    cur;
    chan_t                    upd;
    logic                     in_accept;
    logic                     out_free;
    logic [TICK_W:0]          tick_inc;
    logic signed [VOICE_W-1:0] voice;
    logic [VOICE_W-1:0]       voice_mag;
    logic [7:0]               peak_cand;
    logic [PROD_W-1:0]        prod_mag;
    logic [PROD_W-1:0]        quot_mag;
    logic signed [PROD_W-1:0] quot;
    logic [15:0]              sample_sat;
    logic [7:0]               read_byte;

    sndmix_chan_mem u_chan_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (cur)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign tick_inc  = {1'b0, tick_reg} + (TICK_W + 1)'(1);

    // Scale one channel sample by its volume and derive its peak level
    always_comb
    begin
        voice     = $signed(VOICE_W'($signed(cur.data)))
                  * $signed(VOICE_W'({1'b0, cur.volume[7:2]}));
        voice_mag = voice[VOICE_W-1] ? VOICE_W'(-voice) : VOICE_W'(voice);
        peak_cand = 8'(voice_mag >> PEAK_SHIFT);
    end

    // Divide the scaled sum toward zero and saturate to 16 bits
    always_comb
    begin
        prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        quot_mag = PROD_W'(prod_mag / MIX_DIV);
        quot     = prod_reg[PROD_W-1] ? -$signed(quot_mag) : $signed(quot_mag);
        if (quot > $signed(PROD_W'(32767)))
        begin
            sample_sat = 16'h7FFF;
        end
        else if (quot < -$signed(PROD_W'(32768)))
        begin
            sample_sat = 16'h8000;
        end
        else
        begin
            sample_sat = quot[15:0];
        end
    end

    // Apply a register write to the selected channel entry
    always_comb
    begin
        upd = cur;
        unique case (addr_reg)
            REG_DATA:    upd.data = wdata_reg;
            REG_BANK:    upd.bank = wdata_reg;
            REG_ADDR_HI: upd.address[15:8] = wdata_reg;
            REG_ADDR_LO: upd.address[7:0] = wdata_reg;
            REG_PER_HI:  upd.period_latch = wdata_reg;
            REG_PER_LO:  upd.period = {cur.period_latch, wdata_reg};
            REG_LEN_HI:  upd.length[15:8] = wdata_reg;
            REG_LEN_LO:  upd.length[7:0] = wdata_reg;
            REG_CTRL:
            begin
                upd.active  = |(wdata_reg & CTRL_ACT);
                upd.loop_en = |(wdata_reg & CTRL_LOOP);
            end
            REG_VOL:     upd.volume = wdata_reg & VOL_MASK;
            REG_REP_HI:  upd.repeat_offset[15:8] = wdata_reg;
            REG_REP_LO:  upd.repeat_offset[7:0] = wdata_reg;
            REG_PEAK:    upd.peak = 8'd0;
            REG_UNMAPPED,
            REG_MVOL,
            REG_SELECT:  upd = cur;
            default:     upd = cur;
        endcase
    end

    // Select the byte for a register read
    always_comb
    begin
        unique case (addr_reg)
            REG_DATA:     read_byte = cur.data;
            REG_BANK:     read_byte = cur.bank;
            REG_ADDR_HI:  read_byte = cur.address[15:8];
            REG_ADDR_LO:  read_byte = cur.address[7:0];
            REG_PER_HI:   read_byte = cur.period[15:8];
            REG_PER_LO:   read_byte = cur.period[7:0];
            REG_LEN_HI:   read_byte = cur.length[15:8];
            REG_LEN_LO:   read_byte = cur.length[7:0];
            REG_CTRL:     read_byte = (cur.active ? CTRL_ACT : 8'd0)
                                    | (cur.loop_en ? CTRL_LOOP : 8'd0);
            REG_VOL:      read_byte = cur.volume;
            REG_REP_HI:   read_byte = cur.repeat_offset[15:8];
            REG_REP_LO:   read_byte = cur.repeat_offset[7:0];
            REG_PEAK:     read_byte = cur.peak;
            REG_UNMAPPED: read_byte = UNMAPPED_DATA;
            REG_MVOL:     read_byte = mvol_reg;
            REG_SELECT:   read_byte = 8'(sel_reg);
            default:      read_byte = UNMAPPED_DATA;
        endcase
    end

    // Sequence accesses, mixing and result delivery
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        wdata_next      = wdata_reg;
        tick_next       = tick_reg;
        mvol_next       = mvol_reg;
        sel_next        = sel_reg;
        proc_idx_next   = proc_idx_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_rdata_next  = out_rdata_reg;
        out_sv_next     = out_sv_reg;
        out_sample_next = out_sample_reg;
        mem_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next  = mode_t'(s_tdata[1:0]);
                    addr_next  = reg_t'(s_tdata[5:2]);
                    wdata_next = s_tdata[13:6];
                    mem_req.rd_en = 1'b1;
                    if ((mode_t'(s_tdata[1:0]) == MODE_TICK) &&
                        (tick_inc >= (TICK_W + 1)'(CYCLES_PER_SAMPLE)))
                    begin
                        // Start a mix pass at channel zero
                        tick_next      = TICK_W'(tick_inc - (TICK_W + 1)'(CYCLES_PER_SAMPLE));
                        mem_req.rd_idx = '0;
                        proc_idx_next  = '0;
                        acc_next       = '0;
                        state_next     = S_MIX;
                    end
                    else
                    begin
                        if (mode_t'(s_tdata[1:0]) == MODE_TICK)
                        begin
                            tick_next = TICK_W'(tick_inc);
                        end
                        mem_req.rd_idx = sel_reg;
                        state_next     = S_ACCESS;
                    end
                end
            end

            S_ACCESS:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_rdata_next  = (mode_reg == MODE_READ) ? read_byte : 8'd0;
                    out_sv_next     = 1'b0;
                    out_sample_next = 16'd0;
                    if (mode_reg == MODE_WRITE)
                    begin
                        if (addr_reg == REG_MVOL)
                        begin
                            mvol_next = wdata_reg & VOL_MASK;
                        end
                        else if (addr_reg == REG_SELECT)
                        begin
                            sel_next = CH_W'(wdata_reg % CHANNELS);
                        end
                        else if (addr_reg != REG_UNMAPPED)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_idx  = sel_reg;
                            mem_req.wr_data = upd;
                        end
                    end
                    state_next = S_IDLE;
                end
            end

            S_MIX:
            begin
                // Accumulate, write back the peak, fetch the next channel
                acc_next        = acc_reg + ACC_W'(voice);
                mem_req.wr_en   = 1'b1;
                mem_req.wr_idx  = proc_idx_reg;
                mem_req.wr_data = cur;
                if (peak_cand > cur.peak)
                begin
                    mem_req.wr_data.peak = peak_cand;
                end
                if (proc_idx_reg == LAST_CHAN)
                begin
                    state_next = S_SCALE;
                end
                else
                begin
                    mem_req.rd_en  = 1'b1;
                    mem_req.rd_idx = proc_idx_reg + CH_W'(1);
                    proc_idx_next  = proc_idx_reg + CH_W'(1);
                end
            end

            S_SCALE:
            begin
                prod_next  = $signed(PROD_W'(acc_reg))
                           * $signed(PROD_W'({1'b0, mvol_reg[7:2]}));
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_rdata_next  = 8'd0;
                    out_sv_next     = 1'b1;
                    out_sample_next = sample_sat;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            mvol_reg      <= MVOL_RESET;
            sel_reg       <= '0;
            proc_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            mvol_reg      <= mvol_next;
            sel_reg       <= sel_next;
            proc_idx_reg  <= proc_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        wdata_reg      <= wdata_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        out_rdata_reg  <= out_rdata_next;
        out_sv_reg     <= out_sv_next;
        out_sample_reg <= out_sample_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sample_reg, out_rdata_reg};
    assign m_tuser  = out_sv_reg;

    // Assertions
    `SNDMIX_ASSERT_IMP(a_tick_bound, 1'b1, tick_reg < TICK_W'(CYCLES_PER_SAMPLE),
        "tick count reached the sample period")
    `SNDMIX_ASSERT_IMP(a_wr_state, mem_req.wr_en,
        (state_reg == S_ACCESS) || (state_reg == S_MIX), "channel write outside access or mix")
    `SNDMIX_ASSERT_IMP(a_scale_entry, state_reg == S_SCALE,
        ($past(state_reg) == S_MIX) && ($past(proc_idx_reg) == LAST_CHAN),
        "scale entered before the last channel was mixed")
    `SNDMIX_ASSERT_NXT(a_sample_out, (state_reg == S_FINISH) && out_free,
        m_tvalid && m_tuser[0], "mixed sample not presented after finish")

endmodule

// ----- rtl/core/sndmix_chan_mem.sv -----
// Channel state memory: one write and one registered read per cycle.
// Entries never written read as zero through per-entry valid bits. Uses sndmix_pkg.
module sndmix_chan_mem
    import sndmix_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output chan_t    rd_data
);

    chan_t                mem [CHANNELS];
    chan_t                rd_data_reg;
    logic [CHANNELS-1:0]  valid_reg;
    logic [CHANNELS-1:0]  valid_next;
    logic                 rd_valid_reg;
    logic                 rd_valid_next;

    // Mark entries as written, capture the valid bit of the read entry
    always_comb
    begin
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (req.wr_en)
        begin
            valid_next[req.wr_idx] = 1'b1;
        end
        if (req.rd_en)
        begin
            rd_valid_next = valid_reg[req.rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_idx] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_idx];
        end
    end

    // Return the reset value for entries never written
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
